FILE: sv/xsrl_pkg.sv
// ----------------------------------------------------------------------------
// x86 segment register load: shared types and constants
// Beat formats for load requests and results, segment ids, fault codes,
// configuration register indexes and descriptor field constants.
// ----------------------------------------------------------------------------
package xsrl_pkg;

    localparam int NUM_SEGS = 6;
    localparam int SEG_ID_W = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [SEG_ID_W-1:0] SEG_ES = 3'd0;
    localparam logic [SEG_ID_W-1:0] SEG_CS = 3'd1;
    localparam logic [SEG_ID_W-1:0] SEG_SS = 3'd2;
    localparam logic [SEG_ID_W-1:0] SEG_DS = 3'd3;
    localparam logic [SEG_ID_W-1:0] SEG_FS = 3'd4;
    localparam logic [SEG_ID_W-1:0] SEG_GS = 3'd5;
    localparam logic [SEG_ID_W-1:0] SEG_LAST = 3'd5;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_GP = 2'd1;
    localparam logic [1:0] FAULT_NP = 2'd2;
    localparam logic [1:0] FAULT_TABLE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GDT_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GDT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LDT_BASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LDT_LIMIT = 3'd5;

    localparam logic [15:0] GDT_LIMIT_RST = 16'hFFFF;
    localparam logic [31:0] REAL_LIMIT = 32'h0000_FFFF;
    localparam logic [15:0] ACC_REAL_CLR = 16'h4060;
    localparam logic [11:0] PAGE_FILL = 12'hFFF;

    localparam logic [4:0] TYPE_DATA_LO = 5'h10;
    localparam logic [4:0] TYPE_DATA_HI = 5'h17;
    localparam logic [4:0] TYPE_DATA_RW = 5'h12;
    localparam logic [4:0] TYPE_DATA_RWA = 5'h13;
    localparam logic [4:0] TYPE_DATA_RWD = 5'h16;
    localparam logic [4:0] TYPE_DATA_RWDA = 5'h17;
    localparam logic [4:0] TYPE_CODE_R = 5'h1A;
    localparam logic [4:0] TYPE_CODE_RA = 5'h1B;
    localparam logic [4:0] TYPE_CODE_RC = 5'h1E;
    localparam logic [4:0] TYPE_CODE_RCA = 5'h1F;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  segment_id;
        logic [15:0] selector;
        logic [31:0] desc_low;
        logic [31:0] desc_high;
    } t_load_req;

    typedef struct packed {
        logic [1:0]  fault;
        logic [15:0] error_code;
        logic [31:0] ld_base;
        logic [31:0] ld_limit;
        logic [15:0] ld_access;
        logic        write_valid;
        logic [31:0] write_addr;
        logic [7:0]  write_byte;
        logic [1:0]  cur_privilege;
        logic        stack_32;
        logic        code_32;
    } t_load_rsp;

endpackage

FILE: sv/x86_segment_register_load.sv
// ----------------------------------------------------------------------------
// x86 segment register load with protection checks
// Loads ES, CS, SS, DS, FS or GS from a selector and its descriptor words,
// applies real mode or protected mode rules, reports faults and the
// accessed-bit byte write, and tracks CPL, code size and stack size.
// ----------------------------------------------------------------------------
// A command is held in an input register, and its result strobe and result
// come from a result register that follows it.
// Throughput: one command per cycle; busy stays low, config ready stays high.
// Reset: real mode, GDT limit 0xFFFF, all segments base 0, limit 0xFFFF,
// access 0, CPL 0, 16-bit code and stack. Results cannot be stalled.
module x86_segment_register_load (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  xsrl_pkg::t_load_req           i_req,
    output logic                          o_result_valid,
    output xsrl_pkg::t_load_rsp           o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [xsrl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import xsrl_pkg::*;

    logic        r_pe;
    logic        r_vm;
    logic [31:0] r_gdt_base;
    logic [15:0] r_gdt_limit;
    logic [31:0] r_ldt_base;
    logic [31:0] r_ldt_limit;

    logic        r_in_valid;
    t_load_req   r_in;

    logic [15:0] r_sel [NUM_SEGS];
    logic [31:0] r_base [NUM_SEGS];
    logic [31:0] r_limit [NUM_SEGS];
    logic [15:0] r_acc [NUM_SEGS];
    logic [1:0]  r_cpl;
    logic        r_stack_wide;
    logic        r_code_wide;

    logic        r_out_valid;
    t_load_rsp   r_out;

    logic [SEG_ID_W-1:0] id;
    logic        id_ok;
    logic        real_mode;
    logic [15:0] acc;
    logic [4:0]  seg_type;
    logic [1:0]  dpl;
    logic [1:0]  rpl;
    logic        present;
    logic        off_zero;
    logic [15:0] off;
    logic [31:0] tbl_lim;
    logic [31:0] tbl_base;
    logic        in_table;
    logic [31:0] dsc_base;
    logic [19:0] raw_limit;
    logic [31:0] dsc_limit;
    logic        data_ok;
    logic        ss_ok;
    logic        do_real;
    logic        do_prot;
    logic        do_null;
    logic [1:0]  fault;
    logic [31:0] cur_base;
    logic [31:0] cur_limit;
    logic [15:0] cur_acc;
    logic [31:0] n_base;
    logic [31:0] n_limit;
    logic [15:0] n_acc;
    logic [1:0]  n_cpl;
    logic        n_stack_wide;
    logic        n_code_wide;
    t_load_rsp   n_out;

    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_result_valid = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        id = r_in.cmd ? SEG_CS : r_in.segment_id;
        id_ok = (id <= SEG_LAST);
        real_mode = !r_pe || r_vm;
        acc = r_in.desc_high[23:8];
        seg_type = acc[4:0];
        dpl = acc[6:5];
        rpl = r_in.selector[1:0];
        present = acc[7];
        off = {r_in.selector[15:2], 2'b00};
        off_zero = (r_in.selector[15:2] == 14'd0);
        tbl_lim = r_in.selector[2] ? r_ldt_limit : {16'd0, r_gdt_limit};
        tbl_base = r_in.selector[2] ? r_ldt_base : r_gdt_base;
        in_table = ({16'd0, r_in.selector[15:3], 3'b111} <= tbl_lim);
        dsc_base = {r_in.desc_high[31:24], r_in.desc_high[7:0], r_in.desc_low[31:16]};
        raw_limit = {r_in.desc_high[19:16], r_in.desc_low[15:0]};
        dsc_limit = r_in.desc_high[23] ? {raw_limit, PAGE_FILL} : {12'd0, raw_limit};

        if (seg_type inside {[TYPE_DATA_LO:TYPE_DATA_HI], TYPE_CODE_R, TYPE_CODE_RA}) begin
            data_ok = (dpl >= r_cpl) && (dpl >= rpl);
        end else if (seg_type inside {TYPE_CODE_RC, TYPE_CODE_RCA}) begin
            data_ok = 1'b1;
        end else begin
            data_ok = 1'b0;
        end
        ss_ok = (r_cpl == rpl) && (r_cpl == dpl) && present
              && (seg_type inside {TYPE_DATA_RW, TYPE_DATA_RWA, TYPE_DATA_RWD, TYPE_DATA_RWDA});

        do_real = 1'b0;
        do_prot = 1'b0;
        do_null = 1'b0;
        fault = FAULT_NONE;
        if (id_ok) begin
            if (real_mode) begin
                do_real = 1'b1;
            end else if (id == SEG_CS) begin
                if (in_table) do_prot = 1'b1;
                else fault = FAULT_TABLE;
            end else if (id == SEG_SS) begin
                if (off_zero) fault = FAULT_GP;
                else if (!in_table) fault = FAULT_TABLE;
                else if (!ss_ok) fault = FAULT_GP;
                else do_prot = 1'b1;
            end else begin
                if (off_zero) do_null = 1'b1;
                else if (!in_table) fault = FAULT_TABLE;
                else if (!data_ok) fault = FAULT_GP;
                else if (!present) fault = FAULT_NP;
                else do_prot = 1'b1;
            end
        end

        cur_base = id_ok ? r_base[id] : 32'd0;
        cur_limit = id_ok ? r_limit[id] : 32'd0;
        cur_acc = id_ok ? r_acc[id] : 16'd0;

        if (do_real) begin
            n_base = {12'd0, r_in.selector, 4'd0};
            n_limit = REAL_LIMIT;
            n_acc = cur_acc & ~ACC_REAL_CLR;
        end else if (do_prot) begin
            n_base = dsc_base;
            n_limit = dsc_limit;
            n_acc = acc;
        end else if (do_null) begin
            n_base = 32'd0;
            n_limit = 32'd0;
            n_acc = 16'd0;
        end else begin
            n_base = cur_base;
            n_limit = cur_limit;
            n_acc = cur_acc;
        end

        n_cpl = (do_prot && id == SEG_CS) ? rpl : r_cpl;
        n_code_wide = r_code_wide;
        n_stack_wide = r_stack_wide;
        if (id == SEG_CS && do_real) n_code_wide = 1'b0;
        if (id == SEG_CS && do_prot) n_code_wide = acc[14];
        if (id == SEG_SS && do_real) n_stack_wide = 1'b0;
        if (id == SEG_SS && do_prot) n_stack_wide = acc[14];

        n_out.fault = fault;
        n_out.error_code = (fault != FAULT_NONE) ? off : 16'd0;
        n_out.ld_base = n_base;
        n_out.ld_limit = n_limit;
        n_out.ld_access = n_acc;
        n_out.write_valid = do_prot;
        n_out.write_addr = do_prot
            ? tbl_base + {16'd0, r_in.selector[15:3], 3'b101} : 32'd0;
        n_out.write_byte = do_prot ? {r_in.desc_high[15:9], 1'b1} : 8'd0;
        n_out.cur_privilege = n_cpl;
        n_out.stack_32 = n_stack_wide;
        n_out.code_32 = n_code_wide;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pe <= 1'b0;
            r_vm <= 1'b0;
            r_gdt_base <= 32'd0;
            r_gdt_limit <= GDT_LIMIT_RST;
            r_ldt_base <= 32'd0;
            r_ldt_limit <= 32'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PE:        r_pe <= i_cfg_data[0];
                CFG_VM:        r_vm <= i_cfg_data[0];
                CFG_GDT_BASE:  r_gdt_base <= i_cfg_data;
                CFG_GDT_LIMIT: r_gdt_limit <= i_cfg_data[15:0];
                CFG_LDT_BASE:  r_ldt_base <= i_cfg_data;
                CFG_LDT_LIMIT: r_ldt_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_req;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_cpl <= 2'd0;
            r_stack_wide <= 1'b0;
            r_code_wide <= 1'b0;
            for (int i = 0; i < NUM_SEGS; i++) begin
                r_sel[i] <= 16'd0;
                r_base[i] <= 32'd0;
                r_limit[i] <= REAL_LIMIT;
                r_acc[i] <= 16'd0;
            end
        end else begin
            r_in_valid <= start && !busy;
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_cpl <= n_cpl;
                r_stack_wide <= n_stack_wide;
                r_code_wide <= n_code_wide;
                if (do_real || do_prot || do_null) begin
                    r_sel[id] <= r_in.selector;
                    r_base[id] <= n_base;
                    r_limit[id] <= n_limit;
                    r_acc[id] <= n_acc;
                end
            end
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_result_valid)
        else $error("result beat missing two cycles after command");

    a_fault_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.fault != FAULT_NONE) |-> !o_result.write_valid)
        else $error("faulting load requests a descriptor write");

    a_err_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.error_code[1:0] == 2'b00))
        else $error("error code carries requested privilege bits");

    a_cpl_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |=> $stable(r_cpl))
        else $error("privilege level changed without a load");

    a_cpl_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (!r_pe || r_vm)) |=> $stable(r_cpl))
        else $error("privilege level changed by a real mode load");

endmodule
